>>> src/dtpc_pkg.sv
// Shared types, constants and helper functions for the disparity to point cloud block.
package dtpc_pkg;

    localparam int unsigned NUM_W   = 44;
    localparam int unsigned DEN_W   = 24;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned LIM_MAX = 4096;

    localparam logic [23:0] SAT_POS = 24'h7FFFFF;
    localparam logic [23:0] SAT_NEG = 24'h800000;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_BASELINE  = 3'd4,
        REG_MAX_RANGE = 3'd5,
        REG_STRIDE    = 3'd6,
        REG_WIDTH     = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic [23:0] focal_x;
        logic [23:0] focal_y;
        logic [19:0] center_x;
        logic [19:0] center_y;
        logic [16:0] baseline;
        logic [23:0] max_range;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] disparity;
        logic [23:0]        rgb;
        logic [11:0]        column;
        logic [11:0]        row;
        logic               grid;
    } t_work;

    typedef struct packed {
        logic [23:0]        depth;
        logic               depth_valid;
        logic               point_keep;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [23:0]        packed_rgb;
        logic [11:0]        column;
        logic [11:0]        row;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZMUL,
        S_ZSTART,
        S_ZWAIT,
        S_XMUL,
        S_XSTART,
        S_XWAIT,
        S_YMUL,
        S_YSTART,
        S_YWAIT,
        S_DONE
    } t_state;

    // {sign, |(pos<<8) - center|}
    function automatic logic [20:0] offset_mag(input logic [11:0] pos, input logic [19:0] center);
        logic [19:0] p;
        logic        neg;
        p   = {pos, 8'd0};
        neg = center > p;
        return {neg, neg ? (center - p) : (p - center)};
    endfunction

    function automatic logic [23:0] saturate(input logic [NUM_W-1:0] q, input logic neg);
        logic [23:0] r;
        if (neg) begin
            r = (q > NUM_W'(24'h800000)) ? SAT_NEG : (24'd0 - q[23:0]);
        end else begin
            r = (q > NUM_W'(24'h7FFFFF)) ? SAT_POS : q[23:0];
        end
        return r;
    endfunction

endpackage

>>> src/dtpc_front.sv
// Front end: raster position and stride phase tracking for accepted pixels.
module dtpc_front #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic signed [15:0]  i_disparity,
    input  logic [7:0]          i_blue,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_red,
    input  logic                i_frame_start,
    input  logic [4:0]          i_stride,
    input  logic [12:0]         i_frame_width,
    output dtpc_pkg::t_work     o_work
);

    localparam int unsigned WLIM = (MAX_WIDTH  > dtpc_pkg::LIM_MAX) ? dtpc_pkg::LIM_MAX : MAX_WIDTH;
    localparam int unsigned HLIM = (MAX_HEIGHT > dtpc_pkg::LIM_MAX) ? dtpc_pkg::LIM_MAX : MAX_HEIGHT;

    logic [11:0] r_col, r_row;
    logic [3:0]  r_col_ph, r_row_ph;
    logic [11:0] u, v;
    logic [3:0]  cph, rph;
    logic [4:0]  s;
    logic [12:0] width;
    logic [12:0] u1, v1;
    logic [4:0]  cph1, rph1;

    always_comb begin
        u   = i_frame_start ? 12'd0 : r_col;
        v   = i_frame_start ? 12'd0 : r_row;
        cph = i_frame_start ? 4'd0 : r_col_ph;
        rph = i_frame_start ? 4'd0 : r_row_ph;
        if (i_stride == 5'd0) begin
            s = 5'd1;
        end else if (i_stride > 5'd16) begin
            s = 5'd16;
        end else begin
            s = i_stride;
        end
        if (i_frame_width == 13'd0) begin
            width = 13'd1;
        end else if (i_frame_width > 13'(WLIM)) begin
            width = 13'(WLIM);
        end else begin
            width = i_frame_width;
        end
        u1   = {1'b0, u} + 13'd1;
        v1   = {1'b0, v} + 13'd1;
        cph1 = {1'b0, cph} + 5'd1;
        rph1 = {1'b0, rph} + 5'd1;
        o_work.disparity = i_disparity;
        o_work.rgb       = {i_red, i_green, i_blue};
        o_work.column    = u;
        o_work.row       = v;
        o_work.grid      = (cph == 4'd0) && (rph == 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else if (i_accept) begin
            if (u1 >= width) begin
                r_col    <= '0;
                r_col_ph <= '0;
                if (v1 >= 13'(HLIM)) begin
                    r_row    <= '0;
                    r_row_ph <= '0;
                end else begin
                    r_row    <= v1[11:0];
                    r_row_ph <= (rph1 >= s) ? 4'd0 : rph1[3:0];
                end
            end else begin
                r_col    <= u1[11:0];
                r_col_ph <= (cph1 >= s) ? 4'd0 : cph1[3:0];
                r_row    <= v;
                r_row_ph <= rph;
            end
        end
    end

endmodule

>>> src/dtpc_queue.sv
// Short word queue between front end and back end.
module dtpc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtpc_pkg::t_work i_word,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output dtpc_pkg::t_work o_word
);

    dtpc_pkg::t_work r_mem [dtpc_pkg::QDEPTH];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'(dtpc_pkg::QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> src/dtpc_div.sv
// Restoring divider, one quotient bit per cycle.
module dtpc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dtpc_pkg::NUM_W-1:0]   i_num,
    input  logic [dtpc_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [dtpc_pkg::NUM_W-1:0]   o_quo
);

    logic [dtpc_pkg::NUM_W-1:0] r_num;
    logic [dtpc_pkg::DEN_W-1:0] r_den, r_rem;
    logic [dtpc_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy, r_done;
    logic [dtpc_pkg::DEN_W:0]   trial;
    logic                       qbit;

    always_comb begin
        trial = {r_rem, r_num[dtpc_pkg::NUM_W-1]};
        qbit  = trial >= {1'b0, r_den};
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[dtpc_pkg::NUM_W-2:0], qbit};
            r_rem <= qbit ? dtpc_pkg::DEN_W'(trial - {1'b0, r_den}) : trial[dtpc_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dtpc_pkg::CNT_W'(dtpc_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == dtpc_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> src/dtpc_back.sv
// Back end: depth division, reprojection and the result register.
module dtpc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtpc_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  dtpc_pkg::t_work   i_q_word,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_res_valid,
    output dtpc_pkg::t_result o_res
);

    dtpc_pkg::t_state  r_state, n_state;
    dtpc_pkg::t_work   r_work;
    dtpc_pkg::t_result r_res;
    logic [dtpc_pkg::NUM_W-1:0] r_prod;
    logic [23:0]       r_z, r_px, r_py;
    logic              r_valid, r_keep, r_neg, r_out_valid;
    logic              d_pos;
    logic              div_start, div_done;
    logic [dtpc_pkg::NUM_W-1:0] div_num, div_quo;
    logic [dtpc_pkg::DEN_W-1:0] div_den;
    logic [20:0]       offx, offy;
    logic              zvalid;
    logic              res_free;

    assign d_pos    = !r_work.disparity[15] && (r_work.disparity != 16'sd0);
    assign offx     = dtpc_pkg::offset_mag(r_work.column, i_cfg.center_x);
    assign offy     = dtpc_pkg::offset_mag(r_work.row, i_cfg.center_y);
    assign zvalid   = (div_quo != '0) && (div_quo <= dtpc_pkg::NUM_W'(i_cfg.max_range));
    assign res_free = !r_out_valid || i_pop;

    dtpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            dtpc_pkg::S_IDLE:   if (i_q_valid) n_state = dtpc_pkg::S_ZMUL;
            dtpc_pkg::S_ZMUL:   n_state = d_pos ? dtpc_pkg::S_ZSTART : dtpc_pkg::S_DONE;
            dtpc_pkg::S_ZSTART: n_state = dtpc_pkg::S_ZWAIT;
            dtpc_pkg::S_ZWAIT: begin
                if (div_done) begin
                    n_state = (zvalid && r_work.grid) ? dtpc_pkg::S_XMUL : dtpc_pkg::S_DONE;
                end
            end
            dtpc_pkg::S_XMUL:   n_state = dtpc_pkg::S_XSTART;
            dtpc_pkg::S_XSTART: begin
                n_state = (i_cfg.focal_x == '0) ? dtpc_pkg::S_YMUL : dtpc_pkg::S_XWAIT;
            end
            dtpc_pkg::S_XWAIT:  if (div_done) n_state = dtpc_pkg::S_YMUL;
            dtpc_pkg::S_YMUL:   n_state = dtpc_pkg::S_YSTART;
            dtpc_pkg::S_YSTART: begin
                n_state = (i_cfg.focal_y == '0) ? dtpc_pkg::S_DONE : dtpc_pkg::S_YWAIT;
            end
            dtpc_pkg::S_YWAIT:  if (div_done) n_state = dtpc_pkg::S_DONE;
            dtpc_pkg::S_DONE:   if (res_free) n_state = dtpc_pkg::S_IDLE;
            default:            n_state = dtpc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_num   = r_prod;
        div_den   = i_cfg.focal_x;
        case (r_state)
            dtpc_pkg::S_IDLE:   o_q_pop = i_q_valid;
            dtpc_pkg::S_ZSTART: begin
                div_start = 1'b1;
                div_den   = {6'd0, r_work.disparity[14:0], 3'd0};
            end
            dtpc_pkg::S_XSTART: div_start = (i_cfg.focal_x != '0);
            dtpc_pkg::S_YSTART: begin
                div_start = (i_cfg.focal_y != '0);
                div_den   = i_cfg.focal_y;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dtpc_pkg::S_IDLE: begin
                r_work  <= i_q_word;
                r_valid <= 1'b0;
                r_keep  <= 1'b0;
                r_z     <= '0;
                r_px    <= '0;
                r_py    <= '0;
            end
            dtpc_pkg::S_ZMUL: begin
                r_prod <= dtpc_pkg::NUM_W'(i_cfg.focal_x * i_cfg.baseline);
            end
            dtpc_pkg::S_ZWAIT: begin
                if (div_done) begin
                    r_valid <= zvalid;
                    r_keep  <= zvalid && r_work.grid;
                    r_z     <= zvalid ? div_quo[23:0] : 24'd0;
                end
            end
            dtpc_pkg::S_XMUL: begin
                r_prod <= dtpc_pkg::NUM_W'(offx[19:0] * r_z);
                r_neg  <= offx[20];
            end
            dtpc_pkg::S_XSTART: begin
                if (i_cfg.focal_x == '0) begin
                    r_px <= (r_prod == '0) ? 24'd0 : (r_neg ? dtpc_pkg::SAT_NEG : dtpc_pkg::SAT_POS);
                end
            end
            dtpc_pkg::S_XWAIT: if (div_done) r_px <= dtpc_pkg::saturate(div_quo, r_neg);
            dtpc_pkg::S_YMUL: begin
                r_prod <= dtpc_pkg::NUM_W'(offy[19:0] * r_z);
                r_neg  <= offy[20];
            end
            dtpc_pkg::S_YSTART: begin
                if (i_cfg.focal_y == '0) begin
                    r_py <= (r_prod == '0) ? 24'd0 : (r_neg ? dtpc_pkg::SAT_NEG : dtpc_pkg::SAT_POS);
                end
            end
            dtpc_pkg::S_YWAIT: if (div_done) r_py <= dtpc_pkg::saturate(div_quo, r_neg);
            dtpc_pkg::S_DONE: begin
                if (res_free) begin
                    r_res.depth       <= r_z;
                    r_res.depth_valid <= r_valid;
                    r_res.point_keep  <= r_keep;
                    r_res.point_x     <= r_px;
                    r_res.point_y     <= r_py;
                    r_res.packed_rgb  <= r_work.rgb;
                    r_res.column      <= r_work.column;
                    r_res.row         <= r_work.row;
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtpc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == dtpc_pkg::S_DONE && res_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    a_keep_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_res.point_keep || r_res.depth_valid))
        else $error("point kept without valid depth");
    a_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.depth_valid) |-> (r_res.depth == 24'd0))
        else $error("invalid depth not zero");
    a_point_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.point_keep) |-> (r_res.point_x == 24'sd0 && r_res.point_y == 24'sd0))
        else $error("dropped point carries coordinates");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == dtpc_pkg::S_IDLE && i_q_valid))
        else $error("queue popped while busy");

endmodule

>>> src/disparity_to_point_cloud_top.sv
// Top level: configuration registers, front end, queue and back end.
//
//   channel  direction  handshake          payload
//   pixel    in         push / full        i_disparity, i_blue, i_green, i_red, i_frame_start
//   result   out        empty / pop        o_depth .. o_row
//   config   in         i_cfg_wr_en        i_cfg_index, i_cfg_data
//
// The back end works on one pixel at a time; its divider produces one quotient bit per cycle.
// A non-positive disparity skips the division; a depth out of range or off the stride grid skips
// reprojection; a kept point also divides for x and y (no y division when focal_y is zero).
// A two-word queue lets the front end take pixels while the back end works.
// Reset is synchronous and active low; it clears position counters, queue and the result valid flag.
// The result word holds until popped; the back end stalls only when a second result is ready.
module disparity_to_point_cloud_top #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_disparity,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_red,
    input  logic               i_frame_start,
    output logic               empty,
    input  logic               pop,
    output logic [23:0]        o_depth,
    output logic               o_depth_valid,
    output logic               o_point_keep,
    output logic signed [23:0] o_point_x,
    output logic signed [23:0] o_point_y,
    output logic [23:0]        o_packed_rgb,
    output logic [11:0]        o_column,
    output logic [11:0]        o_row,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    dtpc_pkg::t_cfg    r_cfg;
    logic [4:0]        r_stride;
    logic [12:0]       r_width;
    dtpc_pkg::t_work   front_word, q_word;
    dtpc_pkg::t_result res;
    logic              accept, q_valid, q_pop, res_valid;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x   <= '0;
            r_cfg.focal_y   <= '0;
            r_cfg.center_x  <= '0;
            r_cfg.center_y  <= '0;
            r_cfg.baseline  <= 17'd3932;
            r_cfg.max_range <= 24'd655360;
            r_stride        <= 5'd2;
            r_width         <= 13'd896;
        end else if (i_cfg_wr_en) begin
            case (dtpc_pkg::t_reg_index'(i_cfg_index))
                dtpc_pkg::REG_FOCAL_X:   r_cfg.focal_x   <= i_cfg_data;
                dtpc_pkg::REG_FOCAL_Y:   r_cfg.focal_y   <= i_cfg_data;
                dtpc_pkg::REG_CENTER_X:  r_cfg.center_x  <= i_cfg_data[19:0];
                dtpc_pkg::REG_CENTER_Y:  r_cfg.center_y  <= i_cfg_data[19:0];
                dtpc_pkg::REG_BASELINE:  r_cfg.baseline  <= i_cfg_data[16:0];
                dtpc_pkg::REG_MAX_RANGE: r_cfg.max_range <= i_cfg_data;
                dtpc_pkg::REG_STRIDE:    r_stride        <= i_cfg_data[4:0];
                dtpc_pkg::REG_WIDTH:     r_width         <= i_cfg_data[12:0];
                default:                 r_stride        <= r_stride;
            endcase
        end
    end

    dtpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_disparity   (i_disparity),
        .i_blue        (i_blue),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_frame_start (i_frame_start),
        .i_stride      (r_stride),
        .i_frame_width (r_width),
        .o_work        (front_word)
    );

    dtpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_word  (front_word),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_word  (q_word)
    );

    dtpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_word    (q_word),
        .o_q_pop     (q_pop),
        .i_pop       (pop && res_valid),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign empty         = !res_valid;
    assign o_depth       = res.depth;
    assign o_depth_valid = res.depth_valid;
    assign o_point_keep  = res.point_keep;
    assign o_point_x     = res.point_x;
    assign o_point_y     = res.point_y;
    assign o_packed_rgb  = res.packed_rgb;
    assign o_column      = res.column;
    assign o_row         = res.row;

endmodule

>>> tb/tb_top.sv
// Testbench for disparity_to_point_cloud_top: directed table plus random pixels checked against a predictor.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_RANDOM    = 1300;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned HOLD_CYCLES = 600;

    typedef struct {
        logic [15:0] disparity;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        frame_start;
        logic        has_expect;
        logic [23:0] depth;
        logic        depth_valid;
        logic        point_keep;
        logic [11:0] column;
        logic [11:0] row;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] i_disparity = '0;
    logic [7:0]         i_blue = '0;
    logic [7:0]         i_green = '0;
    logic [7:0]         i_red = '0;
    logic               i_frame_start = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [23:0]        o_depth;
    logic               o_depth_valid;
    logic               o_point_keep;
    logic signed [23:0] o_point_x;
    logic signed [23:0] o_point_y;
    logic [23:0]        o_packed_rgb;
    logic [11:0]        o_column;
    logic [11:0]        o_row;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;

    disparity_to_point_cloud_top u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [23:0] m_focal_x, m_focal_y, m_max_range;
    logic [19:0] m_center_x, m_center_y;
    logic [16:0] m_baseline;
    logic [4:0]  m_stride;
    logic [12:0] m_width;
    logic [11:0] m_col, m_row;
    logic [3:0]  m_col_ph, m_row_ph;

    dtpc_pkg::t_result expected_points[$];
    int unsigned n_errors = 0;
    int unsigned n_popped = 0;
    int unsigned n_kept = 0;
    int unsigned cycles = 0;
    bit          hold_off = 0;
    bit          drain_now = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR word %0d %s: got %h want %h", n_popped, what, got, want);
        n_errors++;
    endtask

    function automatic logic [23:0] reproject(input logic [11:0] pos, input logic [19:0] center,
                                              input logic [23:0] z, input logic [23:0] focal);
        logic [63:0] p, mag, num, q;
        logic        neg;
        p   = {44'd0, pos, 8'd0};
        neg = center > p;
        mag = neg ? center - p : p - center;
        num = mag * z;
        if (focal == 0) begin
            if (num == 0) return 24'd0;
            return neg ? dtpc_pkg::SAT_NEG : dtpc_pkg::SAT_POS;
        end
        q = num / focal;
        if (neg) return (q > 64'h800000) ? dtpc_pkg::SAT_NEG : 24'(-q);
        return (q > 64'h7FFFFF) ? dtpc_pkg::SAT_POS : q[23:0];
    endfunction

    function automatic dtpc_pkg::t_result predict_pixel(input logic [15:0] d, input logic [7:0] b,
                                                        input logic [7:0] g, input logic [7:0] r,
                                                        input logic fs);
        dtpc_pkg::t_result res;
        logic [63:0] z;
        logic        ok;
        int unsigned s, w;
        s = (m_stride == 0) ? 1 : (m_stride > 16) ? 16 : 32'(m_stride);
        w = (m_width == 0) ? 1 : (m_width > 4096) ? 4096 : 32'(m_width);
        if (fs) begin
            m_col = '0; m_row = '0; m_col_ph = '0; m_row_ph = '0;
        end
        z = '0;
        ok = 1'b0;
        if (d != 0 && !d[15]) begin
            z = (64'(m_focal_x) * m_baseline) / (64'(d) << 3);
            ok = (z > 0) && (z <= m_max_range);
        end
        if (!ok) z = '0;
        res.depth = z[23:0];
        res.depth_valid = ok;
        res.point_keep = ok && m_col_ph == 0 && m_row_ph == 0;
        res.point_x = res.point_keep ? reproject(m_col, m_center_x, z[23:0], m_focal_x) : '0;
        res.point_y = res.point_keep ? reproject(m_row, m_center_y, z[23:0], m_focal_y) : '0;
        res.packed_rgb = {r, g, b};
        res.column = m_col;
        res.row = m_row;
        if (32'(m_col) + 1 >= w) begin
            m_col = '0; m_col_ph = '0;
            if (m_row == 12'hFFF) begin
                m_row = '0; m_row_ph = '0;
            end else begin
                m_row++;
                m_row_ph = (32'(m_row_ph) + 1 >= s) ? 4'd0 : m_row_ph + 4'd1;
            end
        end else begin
            m_col++;
            m_col_ph = (32'(m_col_ph) + 1 >= s) ? 4'd0 : m_col_ph + 4'd1;
        end
        return res;
    endfunction

    task automatic write_reg(input dtpc_pkg::t_reg_index idx, input logic [23:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dtpc_pkg::REG_FOCAL_X:   m_focal_x = val;
            dtpc_pkg::REG_FOCAL_Y:   m_focal_y = val;
            dtpc_pkg::REG_CENTER_X:  m_center_x = val[19:0];
            dtpc_pkg::REG_CENTER_Y:  m_center_y = val[19:0];
            dtpc_pkg::REG_BASELINE:  m_baseline = val[16:0];
            dtpc_pkg::REG_MAX_RANGE: m_max_range = val;
            dtpc_pkg::REG_STRIDE:    m_stride = val[4:0];
            dtpc_pkg::REG_WIDTH:     m_width = val[12:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [15:0] d, input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic fs, input bit gaps);
        int unsigned gap;
        gap = gaps ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_disparity <= d;
        i_blue <= b;
        i_green <= g;
        i_red <= r;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_points.insert(expected_points.size(), predict_pixel(d, b, g, r, fs));
    endtask

    task automatic random_pixel(input bit gaps);
        logic [15:0] d;
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 6) d = 16'($urandom_range(1, 2000));
        else if (k == 6) d = 16'($urandom_range(1, 32767));
        else if (k == 7) d = 16'($urandom);
        else if (k == 8) d = 16'($urandom_range(1, 8));
        else d = 16'd0;
        push_pixel(d, 8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 60) == 0, gaps);
    endtask

    task automatic random_config(input bit extreme);
        if (extreme) begin
            write_reg(dtpc_pkg::REG_FOCAL_X, 24'hFFFFFF);
            write_reg(dtpc_pkg::REG_FOCAL_Y, ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd0);
            write_reg(dtpc_pkg::REG_CENTER_X, 24'hFFFFF);
            write_reg(dtpc_pkg::REG_CENTER_Y, 24'd0);
            write_reg(dtpc_pkg::REG_BASELINE, 24'h1FFFF);
            write_reg(dtpc_pkg::REG_MAX_RANGE, 24'hFFFFFF);
            write_reg(dtpc_pkg::REG_STRIDE, 24'($urandom_range(0, 1) ? 0 : 31));
            write_reg(dtpc_pkg::REG_WIDTH, 24'($urandom_range(0, 1) ? 0 : 8191));
        end else begin
            write_reg(dtpc_pkg::REG_FOCAL_X,
                      24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 400000)));
            write_reg(dtpc_pkg::REG_FOCAL_Y,
                      24'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 400000)));
            write_reg(dtpc_pkg::REG_CENTER_X, 24'(20'($urandom)));
            write_reg(dtpc_pkg::REG_CENTER_Y, 24'($urandom_range(0, 20000)));
            write_reg(dtpc_pkg::REG_BASELINE, 24'(17'($urandom)));
            write_reg(dtpc_pkg::REG_MAX_RANGE, 24'($urandom));
            write_reg(dtpc_pkg::REG_STRIDE, 24'($urandom_range(0, 18)));
            write_reg(dtpc_pkg::REG_WIDTH, 24'($urandom_range(1, 40)));
        end
    endtask

    // result side
    initial begin
        dtpc_pkg::t_result want;
        int unsigned gap;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 4);
            if (drain_now) gap = 0;
            if (gap != 0 || hold_off) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (expected_points.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = expected_points.pop_front();
                if (o_depth !== want.depth) report("depth", o_depth, want.depth);
                if (o_depth_valid !== want.depth_valid)
                    report("depth_valid", o_depth_valid, want.depth_valid);
                if (o_point_keep !== want.point_keep)
                    report("point_keep", o_point_keep, want.point_keep);
                if (o_point_x !== want.point_x) report("point_x", o_point_x, want.point_x);
                if (o_point_y !== want.point_y) report("point_y", o_point_y, want.point_y);
                if (o_packed_rgb !== want.packed_rgb)
                    report("packed_rgb", o_packed_rgb, want.packed_rgb);
                if (o_column !== want.column) report("column", o_column, want.column);
                if (o_row !== want.row) report("row", o_row, want.row);
                if (want.point_keep) n_kept++;
            end
            n_popped++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("disparity_to_point_cloud_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_row    dir_rows[$];
        dtpc_pkg::t_result got;
        int unsigned n_dir;
        dir_rows = '{
            '{16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 24'd0, 1'b0, 1'b0, 12'd0, 12'd0},
            '{16'h0001, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 24'd0, 1'b0, 1'b0, 12'd1, 12'd0},
            '{16'h7FFF, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 24'd0, 1'b0, 1'b0, 12'd0, 12'd0},
            '{16'h8000, 8'hA5, 8'h5A, 8'h0F, 1'b0, 1'b1, 24'd0, 1'b0, 1'b0, 12'd3, 12'd0},
            '{16'hFFFF, 8'h01, 8'h80, 8'hF0, 1'b1, 1'b1, 24'd0, 1'b0, 1'b0, 12'd0, 12'd0},
            '{16'h0020, 8'h11, 8'h22, 8'h33, 1'b0, 1'b0, 24'd0, 1'b0, 1'b0, 12'd0, 12'd0},
            '{16'h0040, 8'h44, 8'h55, 8'h66, 1'b0, 1'b0, 24'd0, 1'b0, 1'b0, 12'd0, 12'd0},
            '{16'h0100, 8'h77, 8'h88, 8'h99, 1'b0, 1'b0, 24'd0, 1'b0, 1'b0, 12'd0, 12'd0},
            '{16'h0002, 8'hAA, 8'hBB, 8'hCC, 1'b0, 1'b0, 24'd0, 1'b0, 1'b0, 12'd0, 12'd0}
        };
        m_focal_x = '0; m_focal_y = '0; m_center_x = '0; m_center_y = '0;
        m_baseline = 17'd3932; m_max_range = 24'd655360; m_stride = 5'd2; m_width = 13'd896;
        m_col = '0; m_row = '0; m_col_ph = '0; m_row_ph = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: zero focal_x gives no depth
        foreach (dir_rows[i]) begin
            if (i == 5) begin
                push <= 1'b0;
                wait_drained();
                write_reg(dtpc_pkg::REG_FOCAL_X, 24'd179200);
                write_reg(dtpc_pkg::REG_FOCAL_Y, 24'd179200);
                write_reg(dtpc_pkg::REG_CENTER_X, 24'd2048);
                write_reg(dtpc_pkg::REG_CENTER_Y, 24'd512);
                write_reg(dtpc_pkg::REG_WIDTH, 24'd3);
            end
            push_pixel(dir_rows[i].disparity, dir_rows[i].blue, dir_rows[i].green,
                       dir_rows[i].red, dir_rows[i].frame_start, 1'b0);
            if (dir_rows[i].has_expect) begin
                got = expected_points[$];
                if (got.depth !== dir_rows[i].depth || got.depth_valid !== dir_rows[i].depth_valid
                        || got.point_keep !== dir_rows[i].point_keep
                        || got.column !== dir_rows[i].column || got.row !== dir_rows[i].row)
                    report("table row", i, 0);
            end
        end
        n_dir = dir_rows.size();
        push <= 1'b0;
        wait_drained();

        // long receiver hold while the sender keeps pushing
        hold_off = 1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 0;
            end
            repeat (10) random_pixel(1'b0);
        join
        push <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 13; phase++) begin
            random_config(phase == 3 || phase == 8);
            for (int k = 0; k < N_RANDOM / 13; k++) begin
                random_pixel(phase % 4 != 1);
                if (k == 40 && phase == 5) begin
                    push <= 1'b0;
                    while (expected_points.size() != 0) @(posedge i_clk);
                end
            end
            push <= 1'b0;
            wait_drained();
        end

        drain_now = 1;
        wait_drained();
        $display("covered %0d directed and about %0d random pixels over 13 register settings",
                 n_dir, N_RANDOM);
        $display("%0d words checked, %0d kept points", n_popped, n_kept);
        if (n_errors == 0 && expected_points.size() == 0) begin
            $display("disparity_to_point_cloud_top: match");
        end else begin
            $display("disparity_to_point_cloud_top: mismatch");
        end
        $finish;
    end
endmodule

>>> disparity_to_point_cloud_top.f
src/dtpc_pkg.sv
src/dtpc_front.sv
src/dtpc_queue.sv
src/dtpc_div.sv
src/dtpc_back.sv
src/disparity_to_point_cloud_top.sv
tb/tb_top.sv
